// ===== design/qtdc_pkg.sv =====
// ----------------------------------------------------------------------------
// qtdc_pkg
// shared types and constants for the query term and/or document counter
// ----------------------------------------------------------------------------
package qtdc_pkg;

  localparam int unsigned TermW   = 31;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ActiveW = 5;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_TERM    = 2'd1,
    ACT_END_DOC = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic term_en;      // nonzero document term to match
    logic commit;       // end of document: count and clear marks
    logic doc_touched;  // some slot anywhere was hit in this document
  } cell_ctrl_t;

endpackage

// ===== design/query_term_and_or_doc_counter.sv =====
// ----------------------------------------------------------------------------
// query_term_and_or_doc_counter
// per-query intersection and union document counts over a streamed term list
// ----------------------------------------------------------------------------
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------------
//  command   | start / busy                   | action, query_index, slot_index,
//            |                                | term_id
//  result    | res_strobe_o (one cycle)       | read_query, docs_with_all/any
//  config    | cfg_valid_i / cfg_ready_o      | active_queries
//
//  load, document term and read are accepted without raising busy; a read
//  result appears on the cycle after its transaction
//  end of document runs its own transaction cycle, then holds busy high
//  while the per-cell touched flags ripple through the registered cell chain;
//  the last busy cycle counts and clears
//  reset clears the whole table, marks and counts at once; no clearing pass
//  the receiver cannot stall the result; a result is never held back
//
module query_term_and_or_doc_counter
  import qtdc_pkg::*;
#(
  parameter int unsigned MAX_QUERIES     = 16,
  parameter int unsigned SLOTS_PER_QUERY = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command transaction
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action_i,
  input  logic [3:0]          query_index_i,
  input  logic [2:0]          slot_index_i,
  input  logic [TermW-1:0]    term_id_i,
  // result transaction
  output logic                res_strobe_o,
  output logic [3:0]          read_query_o,
  output logic [CountW-1:0]   docs_with_all_o,
  output logic [CountW-1:0]   docs_with_any_o,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ActiveW-1:0]  cfg_data_i
);

  localparam int unsigned SlotW = (SLOTS_PER_QUERY > 1) ? $clog2(SLOTS_PER_QUERY) : 1;
  localparam int unsigned CntW  = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ActiveW-1:0] active_q;
  logic               accept;
  action_e            act;
  logic               sweep_done;
  logic               load_ok;
  logic [SlotW-1:0]   load_slot;
  cell_ctrl_t         ctrl;

  logic [MAX_QUERIES:0] chain;
  logic [CountW-1:0]    cell_all [MAX_QUERIES];
  logic [CountW-1:0]    cell_any [MAX_QUERIES];
  logic [CountW-1:0]    sel_all, sel_any;

  logic               res_strobe_q;
  logic [3:0]         read_query_q;
  logic [CountW-1:0]  all_q, any_q;

  assign busy        = (state_q == ST_SWEEP);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign act         = action_e'(action_i);

  // ripple window ends when the last cell has seen every touched flag
  assign sweep_done = busy && (cnt_q == CntW'(MAX_QUERIES - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (act == ACT_END_DOC)) begin
          state_d = ST_SWEEP;
          cnt_d   = '0;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      active_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  // broadcast control; the registered chain tail is the document touched flag
  assign ctrl = '{
    term_en:     accept && (act == ACT_TERM) && (term_id_i != '0),
    commit:      sweep_done,
    doc_touched: chain[MAX_QUERIES]
  };

  // loads beyond the table are dropped
  assign load_ok   = accept && (act == ACT_LOAD) && (32'(slot_index_i) < SLOTS_PER_QUERY);
  assign load_slot = SlotW'(slot_index_i);

  assign chain[0] = 1'b0;

  for (genvar q = 0; q < MAX_QUERIES; q++) begin : g_cell
    logic cell_load;
    logic cell_active;

    assign cell_load   = load_ok && (32'(query_index_i) == q);
    // active count above the table size covers every cell
    assign cell_active = (32'(active_q) > q);

    qtdc_cell #(
      .SLOTS_PER_QUERY (SLOTS_PER_QUERY)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .active_i    (cell_active),
      .load_en_i   (cell_load),
      .load_slot_i (load_slot),
      .term_i      (term_id_i),
      .chain_i     (chain[q]),
      .chain_o     (chain[q+1]),
      .all_count_o (cell_all[q]),
      .any_count_o (cell_any[q])
    );
  end

  // read select; an index beyond the table matches no cell and reads zero
  always_comb begin
    sel_all = '0;
    sel_any = '0;
    for (int q = 0; q < MAX_QUERIES; q++) begin
      if (32'(query_index_i) == q) begin
        sel_all = cell_all[q];
        sel_any = cell_any[q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= accept && (act == ACT_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (act == ACT_READ)) begin
      read_query_q <= query_index_i;
      all_q        <= sel_all;
      any_q        <= sel_any;
    end
  end

  assign res_strobe_o    = res_strobe_q;
  assign read_query_o    = read_query_q;
  assign docs_with_all_o = all_q;
  assign docs_with_any_o = any_q;

endmodule

// ===== design/qtdc_cell.sv =====
// ----------------------------------------------------------------------------
// qtdc_cell
// one query: its term slots, hit marks, touched flag and both counters
// ----------------------------------------------------------------------------
module qtdc_cell
  import qtdc_pkg::*;
#(
  parameter int unsigned SLOTS_PER_QUERY = 8,
  parameter int unsigned SlotW = (SLOTS_PER_QUERY > 1) ? $clog2(SLOTS_PER_QUERY) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              active_i,
  input  logic              load_en_i,
  input  logic [SlotW-1:0]  load_slot_i,
  input  logic [TermW-1:0]  term_i,
  input  logic              chain_i,
  output logic              chain_o,
  output logic [CountW-1:0] all_count_o,
  output logic [CountW-1:0] any_count_o
);

  logic [TermW-1:0]           slot_q [SLOTS_PER_QUERY];
  logic [SLOTS_PER_QUERY-1:0] hit_q, hit_d;
  logic [SLOTS_PER_QUERY-1:0] match, slot_valid;
  logic                       touched_q, touched_d;
  logic                       chain_q;
  logic [CountW-1:0]          all_q, all_d, any_q, any_d;
  logic                       has_all, has_one;

  always_comb begin
    for (int s = 0; s < SLOTS_PER_QUERY; s++) begin
      slot_valid[s] = (slot_q[s] != '0);
      match[s]      = ctrl_i.term_en && (slot_q[s] == term_i);
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS_PER_QUERY; s++) begin
      if (load_en_i && (load_slot_i == SlotW'(s))) begin
        hit_d[s] = 1'b0;
      end else if (ctrl_i.commit) begin
        hit_d[s] = 1'b0;
      end else begin
        hit_d[s] = hit_q[s] | match[s];
      end
    end
  end

  assign touched_d = ctrl_i.commit ? 1'b0 : (touched_q | (|match));

  // empty slots count as hit for the intersection
  assign has_all = &(hit_q | ~slot_valid);
  assign has_one = |(hit_q & slot_valid);

  always_comb begin
    all_d = all_q;
    any_d = any_q;
    if (ctrl_i.commit && ctrl_i.doc_touched && active_i) begin
      if (has_all && (all_q != '1)) begin
        all_d = all_q + 1'b1;
      end
      if (has_one && (any_q != '1)) begin
        any_d = any_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS_PER_QUERY; s++) begin
        slot_q[s] <= '0;
      end
      hit_q     <= '0;
      touched_q <= 1'b0;
      chain_q   <= 1'b0;
      all_q     <= '0;
      any_q     <= '0;
    end else begin
      for (int s = 0; s < SLOTS_PER_QUERY; s++) begin
        if (load_en_i && (load_slot_i == SlotW'(s))) begin
          slot_q[s] <= term_i;
        end
      end
      hit_q     <= hit_d;
      touched_q <= touched_d;
      chain_q   <= chain_i | touched_q;
      all_q     <= all_d;
      any_q     <= any_d;
    end
  end

  assign chain_o     = chain_q;
  assign all_count_o = all_q;
  assign any_count_o = any_q;

endmodule

// ===== sim/tb_query_term_and_or_doc_counter.sv =====
// ----------------------------------------------------------------------------
// tb_query_term_and_or_doc_counter
// self-checking bench for the query term and/or document counter: loads query
// slots, streams documents through the block and checks every count read
// against a cycle-free predictor of the term table and the per-query counts
// ----------------------------------------------------------------------------
module tb_query_term_and_or_doc_counter;
  import qtdc_pkg::*;

  localparam int unsigned NumQueries  = 16;
  localparam int unsigned NumSlots    = 8;
  localparam int unsigned NumCells    = NumQueries * NumSlots;
  // the drain wait outlasts the busy window of an end of document
  localparam int unsigned DrainCycles = NumQueries + 8;
  // cycles with no transaction at all before the run is declared hung
  localparam int unsigned StallLimit  = 1000;

  // one count read as the block should return it
  typedef struct {
    logic [3:0]        query;
    logic [CountW-1:0] with_all;
    logic [CountW-1:0] with_any;
  } query_counts_t;

  // predictor of the term table, hit marks and counts, plus the queue of
  // count reads still owed by the block
  class term_hit_scoreboard;
    bit [TermW-1:0]   slot_term [NumCells];
    bit               slot_hit  [NumCells];
    bit               touched;
    bit [CountW-1:0]  all_count [NumQueries];
    bit [CountW-1:0]  any_count [NumQueries];
    bit [ActiveW-1:0] active;
    query_counts_t    expected_reads [$];
    int               errors;
    int               reads_checked;
    int               docs_ended;
    int               docs_touched;

    function void note_active(logic [ActiveW-1:0] value);
      active = value;
    endfunction

    function void note_command(action_e act, logic [3:0] qi, logic [2:0] si,
                               logic [TermW-1:0] term);
      int            last;
      bit            every;
      bit            some;
      query_counts_t counts;
      case (act)
        ACT_LOAD: begin
          // loading a slot also drops its hit mark, even mid-document
          slot_term[qi * NumSlots + si] = term;
          slot_hit[qi * NumSlots + si]  = 1'b0;
        end
        ACT_TERM: begin
          // zero is out of vocabulary; matches span the whole table
          if (term != '0) begin
            for (int k = 0; k < NumCells; k++) begin
              if (slot_term[k] == term) begin
                slot_hit[k] = 1'b1;
                touched     = 1'b1;
              end
            end
          end
        end
        ACT_END_DOC: begin
          last = (active > NumQueries) ? NumQueries : active;
          docs_ended++;
          // untouched documents leave every count alone
          if (touched) begin
            docs_touched++;
            for (int q = 0; q < last; q++) begin
              every = 1'b1;
              some  = 1'b0;
              for (int s = 0; s < NumSlots; s++) begin
                if (slot_term[q * NumSlots + s] != '0) begin
                  if (slot_hit[q * NumSlots + s]) some = 1'b1;
                  else every = 1'b0;
                end
              end
              // an empty query counts as all-hit; counts stop at all ones
              if (every && all_count[q] != '1) all_count[q]++;
              if (some && any_count[q] != '1) any_count[q]++;
            end
          end
          slot_hit = '{default: 1'b0};
          touched  = 1'b0;
        end
        default: begin
          counts.query    = qi;
          counts.with_all = all_count[qi];
          counts.with_any = any_count[qi];
          expected_reads.insert(expected_reads.size(), counts);
        end
      endcase
    endfunction

    function void check_read(logic [3:0] query, logic [CountW-1:0] with_all,
                             logic [CountW-1:0] with_any);
      query_counts_t want;
      if (expected_reads.size() == 0) begin
        $display("%0t: result with no read pending: query %0d all %0d any %0d",
                 $time, query, with_all, with_any);
        errors++;
        return;
      end
      want = expected_reads.pop_front();
      reads_checked++;
      if (query !== want.query) begin
        $display("%0t: read_query expected %0d actual %0d", $time, want.query, query);
        errors++;
      end
      if (with_all !== want.with_all) begin
        $display("%0t: docs_with_all of query %0d expected %0d actual %0d",
                 $time, want.query, want.with_all, with_all);
        errors++;
      end
      if (with_any !== want.with_any) begin
        $display("%0t: docs_with_any of query %0d expected %0d actual %0d",
                 $time, want.query, want.with_any, with_any);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         action_i;
  logic [3:0]         query_index_i;
  logic [2:0]         slot_index_i;
  logic [TermW-1:0]   term_id_i;
  logic               res_strobe_o;
  logic [3:0]         read_query_o;
  logic [CountW-1:0]  docs_with_all_o;
  logic [CountW-1:0]  docs_with_any_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ActiveW-1:0] cfg_data_i;

  term_hit_scoreboard board;
  int                 idle_pct;       // chance in a hundred of a sender idle cycle
  int                 items_sent;
  int                 settings_used;
  int                 quiet_cycles;
  logic [TermW-1:0]   vocab [16];     // terms used for slots and documents

  query_term_and_or_doc_counter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .query_index_i   (query_index_i),
    .slot_index_i    (slot_index_i),
    .term_id_i       (term_id_i),
    .res_strobe_o    (res_strobe_o),
    .read_query_o    (read_query_o),
    .docs_with_all_o (docs_with_all_o),
    .docs_with_any_o (docs_with_any_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // monitor: every handshake is sampled at the rising edge, before the
  // drivers' nonblocking updates land, so the order of processes does not
  // matter; also the watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (start === 1'b1 && busy === 1'b0) begin
        board.note_command(action_e'(action_i), query_index_i, slot_index_i, term_id_i);
        quiet_cycles = 0;
      end
      if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) begin
        board.note_active(cfg_data_i);
        quiet_cycles = 0;
      end
      // results cannot be held off: a strobe is a finished transaction
      if (res_strobe_o === 1'b1) begin
        board.check_read(read_query_o, docs_with_all_o, docs_with_any_o);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles, giving up", $time, quiet_cycles);
        $display("tb_query_term_and_or_doc_counter: errors");
        $finish;
      end
    end
  end

  // drop start and let the given number of cycles pass
  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // one command transaction, with a random gap in front of it; each cycle
  // idles with chance idle_pct; start stays high on return so back-to-back
  // commands need no second assignment
  task automatic issue(action_e act, int qi, int si, logic [TermW-1:0] term);
    while ($urandom_range(99) < idle_pct)
      pause_sender(1);
    start         <= 1'b1;
    action_i      <= act;
    query_index_i <= qi[3:0];
    slot_index_i  <= si[2:0];
    term_id_i     <= term;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
  endtask

  // hold the sender until every count read has come back; the first edge
  // makes sure a read accepted just now is already in the queue
  task automatic drain_reads();
    start <= 1'b0;
    do @(posedge clk_i); while (board.expected_reads.size() != 0);
  endtask

  // new active query count, written only with the block idle; an end of
  // document may still be running after the last read, hence the extra wait
  task automatic write_active(logic [ActiveW-1:0] value);
    drain_reads();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // document terms: mostly known terms, some misses, a few zeros
  function automatic logic [TermW-1:0] doc_term();
    int r = $urandom_range(99);
    if (r < 75) return vocab[$urandom_range(15)];
    if (r < 90) return TermW'($urandom);
    return '0;
  endfunction

  // random traffic: mostly whole documents followed by count reads, with
  // slot reloads, stray reads and stray terms or document ends mixed in
  task automatic run_phase(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1: issue(ACT_LOAD, $urandom_range(15), $urandom_range(7),
                    ($urandom_range(3) == 0) ? '0 : vocab[$urandom_range(15)]);
        2: issue(ACT_READ, $urandom_range(15), $urandom_range(7), TermW'($urandom));
        3: issue($urandom_range(1) ? ACT_TERM : ACT_END_DOC, $urandom_range(15),
                 $urandom_range(7), TermW'($urandom));
        default: begin
          repeat ($urandom_range(1, 6))
            issue(ACT_TERM, $urandom_range(15), $urandom_range(7), doc_term());
          issue(ACT_END_DOC, $urandom_range(15), $urandom_range(7), TermW'($urandom));
          repeat ($urandom_range(0, 2))
            issue(ACT_READ, $urandom_range(15), $urandom_range(7), TermW'($urandom));
          // now and then let every pending read come back before going on
          if ($urandom_range(39) == 0) drain_reads();
        end
      endcase
    end
  endtask

  initial begin
    board         = new;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    action_i      <= ACT_LOAD;
    query_index_i <= '0;
    slot_index_i  <= '0;
    term_id_i     <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    idle_pct      = 0;
    items_sent    = 0;
    settings_used = 0;
    quiet_cycles  = 0;

    // small ids collide often across queries; wide ones toggle every term bit
    vocab[0] = 31'h7FFF_FFFF;
    for (int i = 1; i < 10; i++) vocab[i] = TermW'(i);
    for (int i = 10; i < 16; i++) vocab[i] = TermW'($urandom_range(32'h7FFF_FFFF, 1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_active(5'd16);

    // directed: reset counts, extreme ids and indexes, emptying a slot,
    // ignored zero term, untouched document, empty queries, shared term,
    // reload in the middle of a document
    issue(ACT_READ, 0, 0, '0);
    issue(ACT_READ, 15, 7, '0);
    issue(ACT_LOAD, 0, 0, 31'h7FFF_FFFF);
    issue(ACT_LOAD, 0, 7, 31'd1);
    issue(ACT_LOAD, 1, 3, 31'd5);
    issue(ACT_LOAD, 15, 7, 31'd5);
    issue(ACT_LOAD, 2, 0, 31'd9);
    issue(ACT_LOAD, 2, 0, '0);
    issue(ACT_TERM, 0, 0, '0);
    issue(ACT_TERM, 0, 0, 31'd9);
    issue(ACT_END_DOC, 0, 0, '0);
    issue(ACT_READ, 2, 0, '0);
    issue(ACT_TERM, 0, 0, 31'h7FFF_FFFF);
    issue(ACT_TERM, 0, 0, 31'd1);
    issue(ACT_END_DOC, 0, 0, '0);
    issue(ACT_READ, 0, 0, '0);
    issue(ACT_READ, 2, 0, '0);
    issue(ACT_TERM, 0, 0, 31'd5);
    issue(ACT_LOAD, 1, 3, 31'd6);
    issue(ACT_END_DOC, 0, 0, '0);
    issue(ACT_READ, 1, 0, '0);
    issue(ACT_READ, 15, 0, '0);
    issue(ACT_READ, 0, 0, '0);

    // random phases; an active count above the table size counts the whole
    // table, zero counts nothing; saturation needs 2^32 - 1 documents and is out
    // of reach here, the predictor still models it
    write_active(5'd31);
    idle_pct = 16;
    run_phase(150);
    write_active(5'd0);
    idle_pct = 70;
    run_phase(150);
    write_active(ActiveW'($urandom_range(1, 15)));
    idle_pct = 0;
    run_phase(150);
    write_active(ActiveW'($urandom_range(17, 30)));
    run_phase(150);

    drain_reads();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.expected_reads.size() != 0) begin
      $display("%0t: results still owed expected 0 actual %0d", $time,
               board.expected_reads.size());
    end
    board.errors += board.expected_reads.size();

    $display("run covered %0d commands over %0d documents (%0d with term hits), %0d reads",
             items_sent, board.docs_ended, board.docs_touched, board.reads_checked);
    $display("%0d active query settings, sender gaps at 16 and 70 percent and none",
             settings_used);
    if (board.errors == 0) begin
      $display("tb_query_term_and_or_doc_counter: clean");
    end else begin
      $display("tb_query_term_and_or_doc_counter: errors");
    end
    $finish;
  end

endmodule
